// File: sv/modular_inverse_assert.svh
// Assertion macros shared by the modular inverse block.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MINV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MINV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/minv_pkg.sv
// Package of the modular inverse block: constants, sequencer states, control and status structs.
package minv_pkg;

  localparam int unsigned MINV_WIDTH = 32;
  localparam logic [63:0] MINV_MODULUS_RESET = 64'd998244353;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FINAL
  } minv_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } minv_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } minv_stat_t;

endpackage

// File: sv/minv_core.sv
// Iterative extended Euclid engine with one shared shift-and-subtract unit.
module minv_core import minv_pkg::*; #(
  parameter int unsigned WIDTH = MINV_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  minv_ctrl_t       ctrl_i,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  output minv_stat_t       stat_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic             invertible_o,
  output logic [WIDTH-1:0] gcd_o
);

  localparam int unsigned KW = $clog2(WIDTH);

  minv_state_e      state_q, state_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] mag1_q, mag1_d;
  logic             neg0_q, neg0_d;
  logic             neg1_q, neg1_d;
  logic [KW-1:0]    k_q, k_d;
  logic             reduce_q, reduce_d;

  logic [WIDTH:0]   d_dbl;
  logic             can_shift;
  logic             ge;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] acc_sum;
  logic [WIDTH-1:0] next_mag1;
  logic [WIDTH-1:0] t_red;

  // Shared unit: two compares, one subtract and one coefficient add per cycle.
  assign d_dbl     = {d_q, 1'b0};
  assign can_shift = d_dbl <= {1'b0, a_q};
  assign ge        = a_q >= d_q;
  assign rem       = ge ? (a_q - d_q) : a_q;
  assign acc_sum   = ge ? (acc_q + e_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      reduce_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      reduce_q <= reduce_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
    mag1_q <= mag1_d;
    neg0_q <= neg0_d;
    neg1_q <= neg1_d;
  end

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    d_d       = d_q;
    e_d       = e_q;
    acc_d     = acc_q;
    mag1_d    = mag1_q;
    neg0_d    = neg0_q;
    neg1_d    = neg1_q;
    k_d       = k_q;
    reduce_d  = reduce_q;
    next_mag1 = mag1_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          a_d    = value_i;
          neg0_d = 1'b0;
          if (modulus_i == '0) begin
            // Plain integers: only one has an inverse.
            acc_d   = (value_i == WIDTH'(1)) ? WIDTH'(1) : '0;
            state_d = ST_FINAL;
          end else begin
            d_d      = modulus_i;
            e_d      = '0;
            k_d      = '0;
            reduce_d = 1'b1;
            state_d  = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (can_shift) begin
          d_d = d_dbl[WIDTH-1:0];
          e_d = {e_q[WIDTH-2:0], 1'b0};
          k_d = k_q + KW'(1);
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        a_d   = rem;
        acc_d = acc_sum;
        if (k_q != '0) begin
          d_d = d_q >> 1;
          e_d = e_q >> 1;
          k_d = k_q - KW'(1);
        end else begin
          if (reduce_q) begin
            reduce_d  = 1'b0;
            a_d       = modulus_i;
            b_d       = rem;
            acc_d     = '0;
            next_mag1 = WIDTH'(1);
            neg0_d    = 1'b0;
            neg1_d    = 1'b0;
          end else begin
            a_d       = b_q;
            b_d       = rem;
            acc_d     = mag1_q;
            next_mag1 = acc_sum;
            neg0_d    = neg1_q;
            neg1_d    = !neg1_q;
          end
          mag1_d = next_mag1;
          if (rem == '0) begin
            state_d = ST_FINAL;
          end else begin
            d_d     = rem;
            e_d     = next_mag1;
            k_d     = '0;
            state_d = ST_ALIGN;
          end
        end
      end
      ST_FINAL: begin
        if (ctrl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The coefficient can reach the modulus itself, which reduces to zero.
  assign t_red = ((modulus_i != '0) && (acc_q == modulus_i)) ? '0 : acc_q;

  always_comb begin
    if (a_q == WIDTH'(1)) begin
      inverse_o = (neg0_q && (t_red != '0)) ? (modulus_i - t_red) : t_red;
    end else begin
      inverse_o = '0;
    end
  end

  assign invertible_o = a_q == WIDTH'(1);
  assign gcd_o        = a_q;
  assign stat_o.busy  = state_q != ST_IDLE;
  assign stat_o.done  = state_q == ST_FINAL;

endmodule

// File: sv/modular_inverse.sv
// Top level of the modular inverse block: modulus register, handshakes and output word register.
// The time to a result is data dependent: each division aligns the divisor bit by bit, then
//   subtracts once per quotient bit, and the finished word is then handed over.
// Throughput: one word at a time, set by the single shared shift-and-subtract unit; the next
//   word is taken in the cycle after the engine hands its result to the output register.
// Reset (rst_ni low, asynchronous) empties engine and output register, modulus 998244353.
module modular_inverse import minv_pkg::*; #(
  parameter int unsigned WIDTH = MINV_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             invertible_o,
  output logic [WIDTH-1:0] common_divisor_o
);

  localparam logic [WIDTH-1:0] ModulusReset = WIDTH'(MINV_MODULUS_RESET);

  logic [WIDTH-1:0] modulus_q;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] inverse_q;
  logic             invertible_q;
  logic [WIDTH-1:0] gcd_q;

  minv_ctrl_t       ctrl;
  minv_stat_t       stat;
  logic [WIDTH-1:0] core_inverse;
  logic             core_invertible;
  logic [WIDTH-1:0] core_gcd;
  logic             out_free;

  // The user must rewrite the modulus only while the block is idle, so the engine may read it
  // directly throughout an operation; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // A new word is taken whenever the engine is idle, even while a finished result still
  // waits in the output register; the engine then holds its own result until that
  // register frees up.
  assign in_stall_o = stat.busy;
  assign ctrl.start = in_valid_i && !stat.busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ctrl.ack   = stat.done && out_free;

  minv_core #(
    .WIDTH(WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .value_i      (value_i),
    .modulus_i    (modulus_q),
    .stat_o       (stat),
    .inverse_o    (core_inverse),
    .invertible_o (core_invertible),
    .gcd_o        (core_gcd)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.ack) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload is loaded only when the engine hands over a finished word.
  always_ff @(posedge clk_i) begin
    if (ctrl.ack) begin
      inverse_q    <= core_inverse;
      invertible_q <= core_invertible;
      gcd_q        <= core_gcd;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign inverse_o        = inverse_q;
  assign invertible_o     = invertible_q;
  assign common_divisor_o = gcd_q;

`include "modular_inverse_assert.svh"

  // The flag must agree with the divisor it describes.
  `MINV_ASSERT_NOW(a_flag_matches_gcd, out_valid_o, invertible_o == (common_divisor_o == WIDTH'(1)), "invertible flag disagrees with gcd")
  // Without an inverse the inverse field is zero.
  `MINV_ASSERT_NOW(a_zero_when_none, out_valid_o && !invertible_o, inverse_o == '0, "inverse not zero when none exists")
  // A proper modulus bounds the normalised inverse.
  `MINV_ASSERT_NOW(a_inverse_reduced, out_valid_o && (modulus_q != '0), inverse_o < modulus_q, "inverse not reduced below the modulus")
  // A word handed over by the engine shows up on the output in the following cycle.
  `MINV_ASSERT_NEXT(a_handover_visible, ctrl.ack, out_valid_o, "finished word not presented")

endmodule
